// ----- sv/kid_pkg.sv -----
// Shared types and constants for the keypad integrator debounce block.
// No dependencies; every other file uses it by scoped names.
package kid_pkg;

    // Default sizing
    localparam int NUM_BUTTONS_DEF = 14;
    localparam int COUNT_WIDTH_DEF = 8;
    localparam int QUEUE_DEPTH     = 4;

    // Configuration register indexes
    localparam logic [1:0] REG_INTEGRATOR_MAX = 2'd0;
    localparam logic [1:0] REG_GESTURE_A      = 2'd1;
    localparam logic [1:0] REG_GESTURE_B      = 2'd2;
    localparam logic [1:0] REG_MODE_BUTTON    = 2'd3;

    // Configuration reset values
    localparam logic [7:0] RST_INTEGRATOR_MAX = 8'd8;
    localparam logic [3:0] RST_GESTURE_A      = 4'd0;
    localparam logic [3:0] RST_GESTURE_B      = 4'd8;
    localparam logic [3:0] RST_MODE_BUTTON    = 4'd3;

    // Event kinds
    localparam logic [2:0] KIND_COMMAND = 3'd0;
    localparam logic [2:0] KIND_GSTART  = 3'd1;
    localparam logic [2:0] KIND_GSTOP   = 3'd2;
    localparam logic [2:0] KIND_EQ_ON   = 3'd3;
    localparam logic [2:0] KIND_EQ_OFF  = 3'd4;

    typedef struct packed {
        logic [3:0] button_index;
        logic       pin_level;
    } in_word_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [3:0] event_button;
    } out_word_t;

    // Debounced level change handed from front to back
    typedef struct packed {
        logic [3:0] button;
        logic       level;
    } change_t;

    typedef struct packed {
        logic [7:0] integrator_max;
        logic [3:0] gesture_button_a;
        logic [3:0] gesture_button_b;
        logic [3:0] mode_button;
    } cfg_t;

endpackage

// ----- sv/kid_front.sv -----
// Front end: per-button saturating integrators and debounced levels.
// Emits one change word per debounced level change. Depends on kid_pkg.
module kid_front #(
    parameter int NUM_BUTTONS = kid_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = kid_pkg::COUNT_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  kid_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  kid_pkg::in_word_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output kid_pkg::change_t  q_data,
    output logic              in_range
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [15:0] TOP16 = 16'((32'd1 << COUNT_WIDTH) - 32'd1);

    logic [COUNT_WIDTH-1:0] cnt_reg [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] level_reg;

    logic [IDX_W-1:0]       idx;
    logic [15:0]            lim_wide;
    logic [COUNT_WIDTH-1:0] lim;
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   lvl_cur;
    logic                   lvl_next;
    logic                   accept;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign idx      = IDX_W'(s_data.button_index);
    assign in_range = (32'(s_data.button_index) < NUM_BUTTONS);

    // Effective limit: zero acts as one, clipped to count range
    always_comb begin
        lim_wide = (cfg.integrator_max == 8'd0) ? 16'd1 : {8'd0, cfg.integrator_max};
        if (lim_wide > TOP16) begin
            lim_wide = TOP16;
        end
        lim = lim_wide[COUNT_WIDTH-1:0];
    end

    // Integrator step with saturation and hysteresis
    always_comb begin
        cnt_cur  = cnt_reg[idx];
        lvl_cur  = level_reg[idx];
        cnt_next = cnt_cur;
        lvl_next = lvl_cur;
        if (!s_data.pin_level) begin
            if (cnt_cur != '0) begin
                cnt_next = cnt_cur - 1'b1;
            end
        end else begin
            if (cnt_cur < lim) begin
                cnt_next = cnt_cur + 1'b1;
            end
        end
        if (cnt_next == '0) begin
            lvl_next = 1'b0;
        end else if (cnt_next >= lim) begin
            lvl_next = 1'b1;
            cnt_next = lim;
        end
    end

    assign q_push      = accept && in_range && (lvl_next != lvl_cur);
    assign q_data.button = s_data.button_index;
    assign q_data.level  = lvl_next;

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                cnt_reg[i] <= COUNT_WIDTH'(kid_pkg::RST_INTEGRATOR_MAX);
            end
            level_reg <= '1;
        end else if (accept && in_range) begin
            cnt_reg[idx]   <= cnt_next;
            level_reg[idx] <= lvl_next;
        end
    end

endmodule

// ----- sv/kid_queue.sv -----
// Short register FIFO of change words between front and back.
// Depends on kid_pkg.
module kid_queue #(
    parameter int DEPTH = kid_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  kid_pkg::change_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output kid_pkg::change_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    kid_pkg::change_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_reg, wr_next;
    logic [PTR_W-1:0]     rd_reg, rd_next;
    logic [PTR_W:0]       cnt_reg, cnt_next;

    assign full  = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    // Pointer arithmetic with wrap at DEPTH
    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/kid_back.sv -----
// Back end: decodes change words into events, owns the mode flag and
// the output register. Depends on kid_pkg.
module kid_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  kid_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  kid_pkg::change_t   q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output kid_pkg::out_word_t m_data
);

    logic               mode_reg, mode_next;
    logic               valid_reg, valid_next;
    kid_pkg::out_word_t data_reg;
    logic [2:0]         kind;
    logic               has_evt;
    logic               gesture;

    assign m_valid = valid_reg;
    assign m_data  = data_reg;
    assign q_pop   = !q_empty && (!valid_reg || m_ready);

    // Event decode, gesture wins over mode
    always_comb begin
        gesture   = (q_head.button == cfg.gesture_button_a) ||
                    (q_head.button == cfg.gesture_button_b);
        mode_next = mode_reg;
        has_evt   = 1'b1;
        kind      = kid_pkg::KIND_COMMAND;
        if (!q_head.level) begin
            if (gesture) begin
                kind = kid_pkg::KIND_GSTART;
            end else if (q_head.button == cfg.mode_button) begin
                mode_next = !mode_reg;
                kind = mode_next ? kid_pkg::KIND_EQ_ON : kid_pkg::KIND_EQ_OFF;
            end else begin
                kind = kid_pkg::KIND_COMMAND;
            end
        end else begin
            has_evt = gesture;
            kind    = kid_pkg::KIND_GSTOP;
        end
    end

    // Output register occupancy
    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = has_evt;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (q_pop) begin
                mode_reg <= mode_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && has_evt) begin
            data_reg.event_kind   <= kind;
            data_reg.event_button <= q_head.button;
        end
    end

endmodule

// ----- sv/keypad_integrator_debounce_events.sv -----
// Top level of the keypad integrator debounce block.
// Holds the configuration registers; uses kid_pkg, kid_front, kid_queue, kid_back.
//
// Usage:
//   s_ channel: one raw pin sample word per handshake (button index, level,
//   level 0 means pressed). Indexes at or above NUM_BUTTONS are dropped.
//   m_ channel: one event word per debounced level change that decodes to
//   an event (command press, gesture start/stop, eq on/off).
//   cfg channel: register index and data, always ready; write only while
//   the block is idle.
//   Throughput: one sample per cycle while the change queue is not full, set by
//   the integrator read-modify-write in the front end.
//   Path: with the queue empty and the output register free, the front end
//   writes the change word into the queue at the edge that accepts its sample,
//   and the back end then pops it and registers the event word for output.
//   Stalls: a stalled m_ channel fills the four-word change queue; s_ready
//   drops only when the queue is full.
//   Reset: integrators at the reset maximum, all buttons released, mode off,
//   queue and output register empty, registers at their reset values.
module keypad_integrator_debounce_events #(
    parameter int NUM_BUTTONS = kid_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = kid_pkg::COUNT_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  kid_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output kid_pkg::out_word_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    kid_pkg::cfg_t    cfg_reg;
    kid_pkg::change_t push_data;
    kid_pkg::change_t q_head;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic             in_range;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.integrator_max   <= kid_pkg::RST_INTEGRATOR_MAX;
            cfg_reg.gesture_button_a <= kid_pkg::RST_GESTURE_A;
            cfg_reg.gesture_button_b <= kid_pkg::RST_GESTURE_B;
            cfg_reg.mode_button      <= kid_pkg::RST_MODE_BUTTON;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                kid_pkg::REG_INTEGRATOR_MAX: begin
                    cfg_reg.integrator_max <= cfg_data;
                end
                kid_pkg::REG_GESTURE_A: begin
                    cfg_reg.gesture_button_a <= cfg_data[3:0];
                end
                kid_pkg::REG_GESTURE_B: begin
                    cfg_reg.gesture_button_b <= cfg_data[3:0];
                end
                kid_pkg::REG_MODE_BUTTON: begin
                    cfg_reg.mode_button <= cfg_data[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    kid_front #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data),
        .in_range (in_range)
    );

    kid_queue #(
        .DEPTH (kid_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    kid_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("change queue overflow");

    // Out-of-range samples never reach the queue
    a_range_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !in_range) |-> !q_push)
        else $error("out-of-range sample produced a change");

    // A new event word only follows a queue pop
    a_valid_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(q_pop))
        else $error("event word without a pop");

    // Event kind stays within the defined codes
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.event_kind <= kid_pkg::KIND_EQ_OFF))
        else $error("illegal event kind");

endmodule
